### rtl/log2pm_pkg.sv
// Package for the log2 presence mapper: widths, window constants, stage type, helpers.
`default_nettype none
package log2pm_pkg;

   localparam int MAG_W     = 32;
   localparam int EXP_W     = 5;
   localparam int MANT_W    = 31;
   localparam int FRAC_W    = 16;
   localparam int LOG_W     = 21;
   localparam int PRES_W    = 31;
   localparam int NORM_W    = MAG_W + MANT_W - 1;
   localparam int NUM_CELLS = 16;
   localparam int DIFF_W    = 20;
   localparam int QUO_W     = 18;
   localparam int QLO_W     = 14;
   localparam int RECIP_SH  = 21;
   localparam int SPAN_SH   = 13;

   localparam logic [LOG_W-1:0]  WIN_LO    = LOG_W'(15 << 16);
   localparam logic [LOG_W-1:0]  WIN_HI    = LOG_W'(27 << 16);
   localparam logic [PRES_W-1:0] FULL_Q31  = {PRES_W{1'b1}};
   localparam logic [DIFF_W-1:0] HALF_SPAN = DIFF_W'(393216);
   localparam logic [DIFF_W-1:0] RECIP3    = DIFF_W'(699051);

   typedef struct packed {
      logic              valid;
      logic [EXP_W-1:0]  exp;
      logic [MANT_W-1:0] mant;
      logic [FRAC_W-1:0] frac;
   } stage_type;

   // floor((b * 2^13 + fl) / 3) for b in 0..2 and fl in -2..1
   function automatic logic signed [QLO_W-1:0] qlo_of(input logic [1:0] b,
                                                      input logic [1:0] fl);
      logic signed [QLO_W-1:0] q;
      case ({b, fl})
         4'b00_10: q = -QLO_W'(1);
         4'b00_11: q = -QLO_W'(1);
         4'b00_00: q = QLO_W'(0);
         4'b00_01: q = QLO_W'(0);
         4'b01_10: q = QLO_W'(2730);
         4'b01_11: q = QLO_W'(2730);
         4'b01_00: q = QLO_W'(2730);
         4'b01_01: q = QLO_W'(2731);
         4'b10_10: q = QLO_W'(5460);
         4'b10_11: q = QLO_W'(5461);
         4'b10_00: q = QLO_W'(5461);
         4'b10_01: q = QLO_W'(5461);
         default:  q = QLO_W'(0);
      endcase
      return q;
   endfunction

endpackage
`default_nettype wire

### rtl/log2pm_norm.sv
// Input register, leading-one detect and Q30 mantissa normalization.
`default_nettype none
module log2pm_norm (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      adv,
   input  wire logic                      in_valid,
   input  wire logic [31:0]               in_magnitude,
   output log2pm_pkg::stage_type          st_out
);
   import log2pm_pkg::*;

   logic              v1_ff;
   logic [MAG_W-1:0]  x1_ff;
   logic              v2_ff;
   logic [MAG_W-1:0]  x2_ff;
   logic [EXP_W-1:0]  e2_ff;
   logic [EXP_W-1:0]  e2_in;
   logic [NORM_W-1:0] wide;
   stage_type         st_ff;
   stage_type         st_in;

   always_comb begin
      e2_in = '0;
      for (int k = 1; k < MAG_W; k++) begin
         if (x1_ff[k]) begin
            e2_in = EXP_W'(k);
         end
      end
   end

   always_comb begin
      wide        = {x2_ff, {(MANT_W-1){1'b0}}} >> e2_ff;
      st_in.valid = v2_ff;
      st_in.exp   = e2_ff;
      st_in.mant  = wide[MANT_W-1:0];
      st_in.frac  = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff       <= 1'b0;
         v2_ff       <= 1'b0;
         st_ff.valid <= 1'b0;
      end else if (adv) begin
         v1_ff <= in_valid;
         x1_ff <= in_magnitude;
         v2_ff <= v1_ff;
         x2_ff <= x1_ff;
         e2_ff <= e2_in;
         st_ff <= st_in;
      end
   end

   assign st_out = st_ff;

endmodule
`default_nettype wire

### rtl/log2pm_cell.sv
// One squaring cell: squares the Q30 mantissa and shifts in one fraction bit.
`default_nettype none
module log2pm_cell (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             adv,
   input  log2pm_pkg::stage_type st_i,
   output log2pm_pkg::stage_type st_o
);
   import log2pm_pkg::*;

   logic [2*MANT_W-1:0] sq;
   logic [MANT_W:0]     m2;
   stage_type           st_in;
   stage_type           st_ff;

   always_comb begin
      sq          = {{MANT_W{1'b0}}, st_i.mant} * {{MANT_W{1'b0}}, st_i.mant};
      m2          = sq[2*MANT_W-1:MANT_W-1];
      st_in.valid = st_i.valid;
      st_in.exp   = st_i.exp;
      st_in.mant  = m2[MANT_W] ? m2[MANT_W:1] : m2[MANT_W-1:0];
      st_in.frac  = {st_i.frac[FRAC_W-2:0], m2[MANT_W]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff.valid <= 1'b0;
      end else if (adv) begin
         st_ff <= st_in;
      end
   end

   assign st_o = st_ff;

endmodule
`default_nettype wire

### rtl/log2pm_map.sv
// Window mapping of the Q5.16 log onto Q31 presence, rounded and clamped.
`default_nettype none
module log2pm_map (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             adv,
   input  log2pm_pkg::stage_type st_i,
   output logic                  out_valid,
   output logic [20:0]           out_log_q16,
   output logic [30:0]           out_presence_q31
);
   import log2pm_pkg::*;

   logic                    v1_ff;
   logic [LOG_W-1:0]        lg1_ff;
   logic [LOG_W-1:0]        lg1_in;
   logic [DIFF_W-1:0]       d1_ff;
   logic                    lo1_ff;
   logic                    hi1_ff;
   logic                    v2_ff;
   logic [LOG_W-1:0]        lg2_ff;
   logic [DIFF_W-1:0]       d2_ff;
   logic                    lo2_ff;
   logic                    hi2_ff;
   logic [QUO_W-1:0]        a2_ff;
   logic [2*DIFF_W-1:0]     prod;
   logic [DIFF_W-1:0]       three_a;
   logic [DIFF_W-1:0]       rem;
   logic [DIFF_W-1:0]       r;
   logic signed [QLO_W-1:0] qlo;
   logic [PRES_W:0]         qsum;

   assign lg1_in = {st_i.exp, st_i.frac};
   assign prod   = {{DIFF_W{1'b0}}, d1_ff} * {{DIFF_W{1'b0}}, RECIP3};

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (adv) begin
         v1_ff  <= st_i.valid;
         lg1_ff <= lg1_in;
         d1_ff  <= DIFF_W'(lg1_in - WIN_LO);
         lo1_ff <= (lg1_in <= WIN_LO);
         hi1_ff <= (lg1_in >= WIN_HI);
         v2_ff  <= v1_ff;
         lg2_ff <= lg1_ff;
         d2_ff  <= d1_ff;
         lo2_ff <= lo1_ff;
         hi2_ff <= hi1_ff;
         a2_ff  <= prod[RECIP_SH +: QUO_W];
      end
   end

   always_comb begin
      three_a = DIFF_W'({a2_ff, 1'b0}) + DIFF_W'(a2_ff);
      rem     = d2_ff - three_a;
      r       = HALF_SPAN - d2_ff;
      qlo     = qlo_of(rem[1:0], r[DIFF_W-1:DIFF_W-2]);
      qsum    = {1'b0, a2_ff, {SPAN_SH{1'b0}}}
              + {{(PRES_W+1-QLO_W){qlo[QLO_W-1]}}, qlo};
      if (lo2_ff) begin
         out_presence_q31 = '0;
      end else if (hi2_ff) begin
         out_presence_q31 = FULL_Q31;
      end else begin
         out_presence_q31 = qsum[PRES_W-1:0];
      end
   end

   assign out_valid   = v2_ff;
   assign out_log_q16 = lg2_ff;

endmodule
`default_nettype wire

### rtl/log2_presence_mapper.sv
// Top level: log2 presence mapper, normalizer, chain of squaring cells, mapper, output skid.
// rsp_valid rises once a transaction has passed the normalizer, the squaring cells, the mapper and the output register.
// Throughput: one transaction per cycle while req_stall is low; each of the 16 cells does one squaring per clock.
// req_stall is registered: it rises only when a result is held and the skid slot fills.
// Reset is synchronous, active high, and clears all valid flags; the data registers are not reset.
`default_nettype none
module log2_presence_mapper (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [31:0] req_magnitude,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [20:0]      rsp_log_q16,
   output logic [30:0]      rsp_presence_q31
);
   import log2pm_pkg::*;

   logic              adv;
   stage_type         chain [0:NUM_CELLS];
   logic              map_valid;
   logic [LOG_W-1:0]  map_log;
   logic [PRES_W-1:0] map_pres;
   logic              out_valid_ff;
   logic [LOG_W-1:0]  out_log_ff;
   logic [PRES_W-1:0] out_pres_ff;
   logic              skid_valid_ff;
   logic [LOG_W-1:0]  skid_log_ff;
   logic [PRES_W-1:0] skid_pres_ff;
   logic              out_take;
   logic              incoming;

   assign adv = !skid_valid_ff;

   log2pm_norm u_norm (
      .clock        (clock),
      .reset        (reset),
      .adv          (adv),
      .in_valid     (req_valid),
      .in_magnitude (req_magnitude),
      .st_out       (chain[0])
   );

   for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
      log2pm_cell u_cell (
         .clock (clock),
         .reset (reset),
         .adv   (adv),
         .st_i  (chain[i]),
         .st_o  (chain[i+1])
      );
   end

   log2pm_map u_map (
      .clock            (clock),
      .reset            (reset),
      .adv              (adv),
      .st_i             (chain[NUM_CELLS]),
      .out_valid        (map_valid),
      .out_log_q16      (map_log),
      .out_presence_q31 (map_pres)
   );

   assign out_take = out_valid_ff && !rsp_stall;
   assign incoming = map_valid && adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (out_take) begin
            out_log_ff    <= skid_log_ff;
            out_pres_ff   <= skid_pres_ff;
            skid_valid_ff <= 1'b0;
         end
      end else if (incoming) begin
         if (!out_valid_ff || out_take) begin
            out_valid_ff <= 1'b1;
            out_log_ff   <= map_log;
            out_pres_ff  <= map_pres;
         end else begin
            skid_valid_ff <= 1'b1;
            skid_log_ff   <= map_log;
            skid_pres_ff  <= map_pres;
         end
      end else if (out_take) begin
         out_valid_ff <= 1'b0;
      end
   end

   assign req_stall        = skid_valid_ff;
   assign rsp_valid        = out_valid_ff;
   assign rsp_log_q16      = out_log_ff;
   assign rsp_presence_q31 = out_pres_ff;

   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid holds a transaction while output is empty");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(req_stall) |-> $past(rsp_valid && rsp_stall))
      else $error("req_stall rose without a stalled result");

   a_floor_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_log_q16 <= WIN_LO) |-> (rsp_presence_q31 == '0))
      else $error("presence nonzero at or below window floor");

   a_ceiling_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_log_q16 >= WIN_HI) |-> (rsp_presence_q31 == FULL_Q31))
      else $error("presence not full scale at or above window ceiling");

endmodule
`default_nettype wire

### tb/sv/log2_presence_checker.sv
// Checker for the log2 presence mapper: watches both channels, predicts and compares.
`timescale 1ns / 1ps
module log2_presence_checker (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   input  wire logic                          req_stall,
   input  wire logic [log2pm_pkg::MAG_W-1:0]  req_magnitude,
   input  wire logic                          rsp_valid,
   input  wire logic                          rsp_stall,
   input  wire logic [log2pm_pkg::LOG_W-1:0]  rsp_log_q16,
   input  wire logic [log2pm_pkg::PRES_W-1:0] rsp_presence_q31,
   output int                                 mismatches,
   output int                                 outstanding
);
   import log2pm_pkg::*;

   localparam int          MANT_Q    = 30;
   localparam logic [63:0] TWO_Q30   = 64'h8000_0000;
   localparam int          MAX_LINES = 40;

   typedef struct packed {
      logic [MAG_W-1:0]  magnitude;
      logic [LOG_W-1:0]  log_q16;
      logic [PRES_W-1:0] presence_q31;
   } level_type;

   level_type expected_levels[$];
   int        err_count = 0;

   assign mismatches = err_count;

   // integer part from leading one, fraction from 16 squarings of a Q30 mantissa
   function automatic logic [LOG_W-1:0] log2_q16_of(input logic [MAG_W-1:0] x);
      logic [63:0]       m;
      logic [EXP_W-1:0]  e;
      logic [FRAC_W-1:0] bits;
      int                k;
      if (x == '0) return '0;
      e = '0;
      for (k = 1; k < MAG_W; k++)
         if ((x >> k) != '0) e = EXP_W'(k);
      m = (64'(x) << MANT_Q) >> e;
      bits = '0;
      for (k = 0; k < FRAC_W; k++) begin
         m = (m * m) >> MANT_Q;
         bits = bits << 1;
         if (m >= TWO_Q30) begin
            m = m >> 1;
            bits[0] = 1'b1;
         end
      end
      return {e, bits};
   endfunction

   // linear map of the log over the window onto Q31, round half up, clamped
   function automatic logic [PRES_W-1:0] presence_of_log(input logic [MAG_W-1:0] x,
                                                         input logic [LOG_W-1:0] lg);
      logic [63:0] span;
      logic [63:0] num;
      span = 64'(WIN_HI - WIN_LO);
      if (x == '0 || lg <= WIN_LO) return '0;
      if (lg >= WIN_HI) return FULL_Q31;
      num = 64'(lg - WIN_LO) * 64'(FULL_Q31) + span / 2;
      return PRES_W'(num / span);
   endfunction

   task automatic report(input string what, input logic [MAG_W-1:0] mag,
                         input logic [31:0] got, input logic [31:0] want);
      if (err_count < MAX_LINES)
         $display("ERROR %0t ns: %s for magnitude 0x%08h: got 0x%0h, expected 0x%0h",
                  $realtime, what, mag, got, want);
      err_count++;
   endtask

   always @(posedge clock) begin
      level_type lv;
      level_type head;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            lv.magnitude    = req_magnitude;
            lv.log_q16      = log2_q16_of(req_magnitude);
            lv.presence_q31 = presence_of_log(req_magnitude, lv.log_q16);
            expected_levels.push_back(lv);
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_levels.size() == 0) begin
               report("unexpected transaction", '0, 32'(rsp_log_q16), '0);
            end else begin
               head = expected_levels.pop_front();
               if (rsp_log_q16 !== head.log_q16)
                  report("log_q16", head.magnitude, 32'(rsp_log_q16), 32'(head.log_q16));
               if (rsp_presence_q31 !== head.presence_q31)
                  report("presence_q31", head.magnitude, 32'(rsp_presence_q31),
                         32'(head.presence_q31));
            end
         end
      end
      outstanding <= expected_levels.size();
   end

endmodule

### tb/sv/tb_log2_presence_mapper.sv
// Testbench top for the log2 presence mapper: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb_log2_presence_mapper;
   import log2pm_pkg::*;

   localparam int RANDOM_ITEMS = 1400;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 40;

   logic              clock;
   logic              reset            = 1'b1;
   logic              req_valid        = 1'b0;
   logic              req_stall;
   logic [MAG_W-1:0]  req_magnitude    = '0;
   logic              rsp_valid;
   logic              rsp_stall        = 1'b0;
   logic [LOG_W-1:0]  rsp_log_q16;
   logic [PRES_W-1:0] rsp_presence_q31;

   int mismatches;
   int outstanding;
   int cycles     = 0;
   bit tx_quiet   = 1'b0;
   bit rx_quiet   = 1'b0;
   int rx_hold    = 0;

   log2_presence_mapper DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_magnitude    (req_magnitude),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_log_q16      (rsp_log_q16),
      .rsp_presence_q31 (rsp_presence_q31)
   );

   log2_presence_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_magnitude    (req_magnitude),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_log_q16      (rsp_log_q16),
      .rsp_presence_q31 (rsp_presence_q31),
      .mismatches       (mismatches),
      .outstanding      (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("log2_presence_mapper: mismatch");
         $finish;
      end
   end

   // result side: stall for a drawn number of cycles after each transaction
   always @(posedge clock) begin
      int n;
      if (reset) begin
         rsp_stall <= 1'b0;
         rx_hold   <= 0;
      end else if (rsp_valid && !rsp_stall) begin
         if ($urandom_range(0, 15) == 0) rx_quiet = ~rx_quiet;
         n = rx_quiet ? 0 : $urandom_range(0, 11);
         rx_hold   <= n;
         rsp_stall <= (n != 0);
      end else if (rx_hold != 0) begin
         rx_hold   <= rx_hold - 1;
         rsp_stall <= (rx_hold > 1);
      end
   end

   task automatic send(input logic [MAG_W-1:0] mag);
      int gap;
      if ($urandom_range(0, 23) == 0) tx_quiet = ~tx_quiet;
      gap = tx_quiet ? 0 : $urandom_range(0, 11);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_magnitude <= mag;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   function automatic logic [MAG_W-1:0] random_magnitude();
      logic [MAG_W-1:0] p;
      case ($urandom_range(0, 9)) inside
         [0:3]:   return $urandom;
         [4:7]:   return $urandom >> $urandom_range(4, 17);
         8:       return $urandom >> $urandom_range(18, 31);
         default: begin
            p = MAG_W'(1) << $urandom_range(0, 31);
            return p + MAG_W'($urandom_range(0, 2)) - MAG_W'(1);
         end
      endcase
   endfunction

   initial begin
      logic [MAG_W-1:0] directed[$];
      directed = '{32'h0000_0000, 32'h0000_0001, 32'h0000_0002, 32'h0000_0003,
                   32'h0000_7FFF, 32'h0000_8000, 32'h0000_8001, 32'h0000_B505,
                   32'h0010_0000, 32'h0020_0000, 32'h07FF_FFFF, 32'h0800_0000,
                   32'h0800_0001, 32'h7FFF_FFFE, 32'h7FFF_FFFF, 32'h8000_0000,
                   32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555,
                   32'h0001_6A09, 32'h00B5_04F3, 32'h0000_FFFF, 32'h0400_0000};
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i]) send(directed[i]);
      drain_results();

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == RANDOM_ITEMS / 2) drain_results();
         send(random_magnitude());
      end
      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0 && outstanding == 0)
         $display("log2_presence_mapper: match");
      else
         $display("log2_presence_mapper: mismatch");
      $finish;
   end

endmodule
